### hdl/idel_pkg.sv
// ----------------------------------------------------------------------------
// idel_pkg
// Shared types and constants for the indexed double-ended list.
// ----------------------------------------------------------------------------
package idel_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int ACT_W    = 3;
  localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_TAIL = 3'd0,
    ACT_PUSH_HEAD = 3'd1,
    ACT_POP_TAIL  = 3'd2,
    ACT_POP_HEAD  = 3'd3,
    ACT_INSERT    = 3'd4,
    ACT_REMOVE    = 3'd5,
    ACT_READ      = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic                     load;
    logic [IDX_W-1:0]         ld_idx;
    logic signed [DATA_W-1:0] value;
    logic                     shift_up;    // cells above 'at' take the left neighbor
    logic                     shift_down;  // cells at or above 'at' take the right one
    logic [IDX_W-1:0]         at;
  } ctl_t;

  // Per-command result from the decoder.
  typedef struct packed {
    logic               found;
    status_t            status;
    logic [IDX_W-1:0]   rd_idx;
    logic [COUNT_W-1:0] count_nxt;
  } res_t;

endpackage

### hdl/idel_cell.sv
// ----------------------------------------------------------------------------
// idel_cell
// One list slot: holds one value and picks its next value from the command
// broadcast, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module idel_cell (
  input  logic                              clk,
  input  logic [idel_pkg::IDX_W-1:0]        my_idx,
  input  idel_pkg::ctl_t                    ctl,
  input  logic signed [idel_pkg::DATA_W-1:0] left_val,
  input  logic signed [idel_pkg::DATA_W-1:0] right_val,
  output logic signed [idel_pkg::DATA_W-1:0] val_o
);
  import idel_pkg::*;

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  always_comb begin
    priority if (ctl.load && (my_idx == ctl.ld_idx)) begin
      val_nxt = ctl.value;
    end else if (ctl.shift_up && (my_idx > ctl.at)) begin
      val_nxt = left_val;
    end else if (ctl.shift_down && (my_idx >= ctl.at)) begin
      val_nxt = right_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

### hdl/idel_ctrl.sv
// ----------------------------------------------------------------------------
// idel_ctrl
// Command decoder: checks the command against the count and builds the
// broadcast for the cell row plus the result fields.
// ----------------------------------------------------------------------------
module idel_ctrl (
  input  logic                           go,
  input  logic [idel_pkg::ACT_W-1:0]     action,
  input  logic signed [idel_pkg::DATA_W-1:0] value,
  input  logic [idel_pkg::POS_W-1:0]     position,
  input  logic [idel_pkg::COUNT_W-1:0]   count,
  output idel_pkg::ctl_t                 ctl,
  output idel_pkg::res_t                 res
);
  import idel_pkg::*;

  logic             full;
  logic             empty;
  logic             out_of_range;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_inc;
  ctl_t             ctl_raw;

  assign pos_ext      = CMP_W'(position);
  assign pos_inc      = pos_ext + CMP_W'(1);
  assign full         = (count >= COUNT_W'(CAPACITY));
  assign empty        = (count == '0);
  assign out_of_range = (pos_ext >= CMP_W'(count));

  always_comb begin
    ctl_raw       = '0;
    ctl_raw.value = value;
    res.found     = 1'b0;
    res.status    = ST_OK;
    res.rd_idx    = '0;
    res.count_nxt = count;
    unique case (action_t'(action))
      ACT_PUSH_TAIL: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl_raw.load   = 1'b1;
          ctl_raw.ld_idx = IDX_W'(count);
          res.count_nxt  = count + COUNT_W'(1);
        end
      end
      ACT_PUSH_HEAD: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          ctl_raw.load     = 1'b1;
          ctl_raw.shift_up = 1'b1;
          res.count_nxt    = count + COUNT_W'(1);
        end
      end
      ACT_POP_TAIL: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.found     = 1'b1;
          res.rd_idx    = IDX_W'(count - COUNT_W'(1));
          res.count_nxt = count - COUNT_W'(1);
        end
      end
      ACT_POP_HEAD: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.found          = 1'b1;
          ctl_raw.shift_down = 1'b1;
          res.count_nxt      = count - COUNT_W'(1);
        end
      end
      ACT_INSERT: begin
        priority if (full) begin
          res.status = ST_FULL;
        end else if (empty) begin
          res.status = ST_EMPTY;
        end else if (out_of_range) begin
          res.status = ST_RANGE;
        end else begin
          ctl_raw.load     = 1'b1;
          ctl_raw.shift_up = 1'b1;
          ctl_raw.ld_idx   = IDX_W'(pos_inc);
          ctl_raw.at       = IDX_W'(pos_inc);
          res.count_nxt    = count + COUNT_W'(1);
        end
      end
      ACT_REMOVE, ACT_READ: begin
        priority if (empty) begin
          res.status = ST_EMPTY;
        end else if (out_of_range) begin
          res.status = ST_RANGE;
        end else begin
          res.found  = 1'b1;
          res.rd_idx = IDX_W'(pos_ext);
          if (action_t'(action) == ACT_REMOVE) begin
            ctl_raw.shift_down = 1'b1;
            ctl_raw.at         = IDX_W'(pos_ext);
            res.count_nxt      = count - COUNT_W'(1);
          end
        end
      end
      default: begin
        // unused code: no change
      end
    endcase
  end

  // the row only moves on a transfer
  always_comb begin
    ctl            = ctl_raw;
    ctl.load       = ctl_raw.load & go;
    ctl.shift_up   = ctl_raw.shift_up & go;
    ctl.shift_down = ctl_raw.shift_down & go;
  end

endmodule

### hdl/indexed_double_ended_list.sv
// ----------------------------------------------------------------------------
// indexed_double_ended_list
// Bounded ordered list of up to CAPACITY signed 32-bit values with push and
// pop at both ends, insert after / remove at / read at a position. Each
// command transfer yields exactly one result: the value read or removed,
// a found flag, a status (ok, full, empty, position out of range) and the
// count after the command. The list lives in a row of cells, one per
// position; a transfer may shift the row up or down from a position and
// load a value into one cell, all as one registered update, and a new command
// is taken in every cycle in which the result register is empty or its
// result is being taken. The read of a position goes through an AND-OR
// select over the row in the same cycle. No clearing pass after reset:
// entries above the count are never read.
// ----------------------------------------------------------------------------
module indexed_double_ended_list (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [idel_pkg::ACT_W-1:0]         in_action,
  input  logic signed [idel_pkg::DATA_W-1:0] in_value,
  input  logic [idel_pkg::POS_W-1:0]         in_position,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [idel_pkg::DATA_W-1:0] out_read_value,
  output logic                               out_found,
  output logic [1:0]                         out_status,
  output logic [idel_pkg::COUNT_W-1:0]       out_count
);
  import idel_pkg::*;

  logic                     in_xfer;
  logic [COUNT_W-1:0]       count_r;
  logic [COUNT_W-1:0]       count_nxt;
  ctl_t                     ctl;
  res_t                     res;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic signed [DATA_W-1:0] sel_val;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic                     out_found_r;
  status_t                  out_status_r;
  logic [COUNT_W-1:0]       out_count_r;

  // Next command goes in once the result register is free or draining.
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  idel_ctrl u_ctrl (
    .go       (in_xfer),
    .action   (in_action),
    .value    (in_value),
    .position (in_position),
    .count    (count_r),
    .ctl      (ctl),
    .res      (res)
  );

  // Row of cells; each end feeds its own value back where it has no neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = cell_val[i];
    end else begin : g_left
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_right
      assign right_v = cell_val[i+1];
    end
    idel_cell u_cell (
      .clk       (clk),
      .my_idx    (IDX_W'(i)),
      .ctl       (ctl),
      .left_val  (left_v),
      .right_val (right_v),
      .val_o     (cell_val[i])
    );
  end

  // AND-OR select of the addressed cell, taken before the row moves.
  always_comb begin
    sel_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      sel_val = sel_val | (cell_val[j] & {DATA_W{res.rd_idx == IDX_W'(j)}});
    end
  end

  assign count_nxt     = in_xfer ? res.count_nxt : count_r;
  assign out_valid_nxt = in_xfer || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded on each command transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_read_value_r <= res.found ? sel_val : '0;
      out_found_r      <= res.found;
      out_status_r     <= res.status;
      out_count_r      <= res.count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_found      = out_found_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_fail_no_change : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (res.status != ST_OK)) |=> (count_r == $past(count_r)))
    else $error("failed command changed the count");

  a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == ST_OK))
    else $error("found set on a failed command");

  a_count_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_count_r == count_r))
    else $error("reported count differs from stored count");

endmodule
